// File: sv/assert_macros.svh
// Assertion helpers for the vertex transform pipeline.
// Assumes clk and rst_n are visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define VTV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define VTV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/vtv_pkg.sv
// Shared widths, register codes and pipeline payload types.
// No dependencies.
package vtv_pkg;

    localparam int COORD_W         = 16;
    localparam int PROD_W          = 2 * COORD_W;
    localparam int CLIP_W          = PROD_W + 2;
    localparam int SUM_W           = CLIP_W + 1;
    localparam int SIZE_W          = 12;
    localparam int SNUM_W          = SUM_W + SIZE_W + 1;
    localparam int NUM_W           = SNUM_W - 1;
    localparam int DEN_W           = CLIP_W + 1;
    localparam int QUO_W           = 16;
    localparam int CMP_W           = DEN_W + QUO_W;
    localparam int DEPTH_FRAC_BITS = 13;
    localparam int ROW_W           = 64;
    localparam int NUM_LANES       = 3;
    localparam int LANE_X          = 0;
    localparam int LANE_Y          = 1;
    localparam int LANE_Z          = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int SCREEN_W        = 12;
    localparam int DEPTH_W         = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0,
        REG_ROW1,
        REG_ROW2,
        REG_ROW3,
        REG_WIDTH,
        REG_HEIGHT
    } cfg_reg_t;

    typedef logic signed [CLIP_W-1:0] clip_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] w;
    } vert_t;

    typedef struct packed {
        clip_t cx;
        clip_t cy;
        clip_t cz;
        clip_t cw;
    } clip_vec_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        logic w_zero;
        logic in_range;
    } flags_t;

endpackage

// File: sv/vtv_mac.sv
// Matrix-vector stage: 16 parallel products, then four row sums.
// Uses vtv_pkg.
module vtv_mac
    import vtv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vert_t                in_vert,
    input  logic [ROW_W-1:0]     row [4],
    output logic                 out_valid,
    input  logic                 out_ready,
    output clip_vec_t            out_clip
);

    logic signed [PROD_W-1:0] prod_reg  [4][4];
    logic signed [PROD_W-1:0] prod_next [4][4];
    logic                     prod_valid_reg;
    clip_t                    clip_reg  [4];
    clip_t                    clip_next [4];
    logic                     clip_valid_reg;
    logic signed [COORD_W-1:0] vin [4];
    logic                     adv_prod;
    logic                     adv_clip;

    assign vin[0] = in_vert.x;
    assign vin[1] = in_vert.y;
    assign vin[2] = in_vert.z;
    assign vin[3] = in_vert.w;

    assign adv_clip = !clip_valid_reg || out_ready;
    assign adv_prod = !prod_valid_reg || adv_clip;
    assign in_ready = adv_prod;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_next[r][k] = $signed(row[r][16*k +: 16]) * vin[k];
            end
            clip_next[r] = CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1])
                         + CLIP_W'(prod_reg[r][2]) + CLIP_W'(prod_reg[r][3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            clip_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_prod)
            begin
                prod_valid_reg <= in_valid;
            end
            if (adv_clip)
            begin
                clip_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_prod && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (adv_clip && prod_valid_reg)
        begin
            clip_reg <= clip_next;
        end
    end

    assign out_valid   = clip_valid_reg;
    assign out_clip.cx = clip_reg[0];
    assign out_clip.cy = clip_reg[1];
    assign out_clip.cz = clip_reg[2];
    assign out_clip.cw = clip_reg[3];

endmodule

// File: sv/vtv_prep.sv
// Builds dividend/divisor magnitudes for the three quotients (3 stages).
// Uses vtv_pkg.
module vtv_prep
    import vtv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  clip_vec_t         in_clip,
    input  logic [SIZE_W-1:0] frame_width,
    input  logic [SIZE_W-1:0] frame_height,
    output logic              out_valid,
    input  logic              out_ready,
    output div_lane_t         out_lane [NUM_LANES],
    output flags_t            out_flags
);

    // stage A: offsets and flags
    logic signed [SUM_W-1:0]  sx_sum_reg, sy_sum_reg;
    clip_t                    cz_a_reg, cw_a_reg;
    flags_t                   flags_a_reg;
    logic                     valid_a_reg;
    logic [CLIP_W-1:0]        abs_cz, abs_cw;
    // stage B: numerators
    logic signed [SNUM_W-1:0] snum_reg [NUM_LANES];
    clip_t                    cw_b_reg;
    flags_t                   flags_b_reg;
    logic                     valid_b_reg;
    logic [SIZE_W-1:0]        wm1, hm1;
    // stage C: magnitudes
    div_lane_t                lane_reg  [NUM_LANES];
    div_lane_t                lane_next [NUM_LANES];
    flags_t                   flags_c_reg;
    logic                     valid_c_reg;
    logic [CLIP_W-1:0]        abs_cw_b;
    logic                     adv_a, adv_b, adv_c;

    assign adv_c    = !valid_c_reg || out_ready;
    assign adv_b    = !valid_b_reg || adv_c;
    assign adv_a    = !valid_a_reg || adv_b;
    assign in_ready = adv_a;

    assign abs_cz   = in_clip.cz[CLIP_W-1] ? CLIP_W'(-in_clip.cz) : in_clip.cz;
    assign abs_cw   = in_clip.cw[CLIP_W-1] ? CLIP_W'(-in_clip.cw) : in_clip.cw;
    // a zero size counts as one: scale is zero
    assign wm1      = (frame_width  == '0) ? '0 : frame_width  - 1'b1;
    assign hm1      = (frame_height == '0) ? '0 : frame_height - 1'b1;
    assign abs_cw_b = cw_b_reg[CLIP_W-1] ? CLIP_W'(-cw_b_reg) : cw_b_reg;

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            lane_next[l].num = snum_reg[l][SNUM_W-1] ? NUM_W'(-snum_reg[l])
                                                     : NUM_W'(snum_reg[l]);
            lane_next[l].den = (l == LANE_Z) ? {1'b0, abs_cw_b} : {abs_cw_b, 1'b0};
            lane_next[l].quo = '0;
            lane_next[l].neg = snum_reg[l][SNUM_W-1] ^ cw_b_reg[CLIP_W-1];
            lane_next[l].ovf = CMP_W'(lane_next[l].num)
                               >= {lane_next[l].den, {QUO_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            if (adv_a) valid_a_reg <= in_valid;
            if (adv_b) valid_b_reg <= valid_a_reg;
            if (adv_c) valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            sx_sum_reg           <= SUM_W'(in_clip.cx) + SUM_W'(in_clip.cw);
            sy_sum_reg           <= SUM_W'(in_clip.cw) - SUM_W'(in_clip.cy);
            cz_a_reg             <= in_clip.cz;
            cw_a_reg             <= in_clip.cw;
            flags_a_reg.w_zero   <= (in_clip.cw == '0);
            flags_a_reg.in_range <= (abs_cz <= abs_cw) && (in_clip.cw != '0);
        end
        if (adv_b && valid_a_reg)
        begin
            snum_reg[LANE_X] <= sx_sum_reg * $signed({1'b0, wm1});
            snum_reg[LANE_Y] <= sy_sum_reg * $signed({1'b0, hm1});
            snum_reg[LANE_Z] <= SNUM_W'(cz_a_reg) <<< DEPTH_FRAC_BITS;
            cw_b_reg         <= cw_a_reg;
            flags_b_reg      <= flags_a_reg;
        end
        if (adv_c && valid_b_reg)
        begin
            lane_reg    <= lane_next;
            flags_c_reg <= flags_b_reg;
        end
    end

    assign out_valid = valid_c_reg;
    assign out_lane  = lane_reg;
    assign out_flags = flags_c_reg;

endmodule

// File: sv/vtv_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// Uses vtv_pkg.
module vtv_div
    import vtv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_lane_t in_lane [NUM_LANES],
    input  flags_t    in_flags,
    output logic      out_valid,
    input  logic      out_ready,
    output div_lane_t out_lane [NUM_LANES],
    output flags_t    out_flags
);

    div_lane_t  lane_reg  [QUO_W][NUM_LANES];
    div_lane_t  lane_next [QUO_W][NUM_LANES];
    flags_t     flags_reg [QUO_W];
    logic       valid_reg [QUO_W];
    logic       adv       [QUO_W+1];

    assign adv[QUO_W] = out_ready;
    assign in_ready   = adv[0];

    genvar s, l;
    generate
        for (s = 0; s < QUO_W; s++)
        begin : g_stage
            localparam int BIT = QUO_W - 1 - s;

            assign adv[s] = !valid_reg[s] || adv[s+1];

            for (l = 0; l < NUM_LANES; l++)
            begin : g_lane
                div_lane_t         src;
                logic [CMP_W-1:0]  dsh;
                logic [CMP_W-1:0]  rem;
                logic              fits;

                if (s == 0)
                begin : g_first
                    assign src = in_lane[l];
                end
                else
                begin : g_rest
                    assign src = lane_reg[s-1][l];
                end

                assign dsh  = CMP_W'(src.den) << BIT;
                assign rem  = CMP_W'(src.num);
                assign fits = rem >= dsh;

                always_comb
                begin
                    lane_next[s][l] = src;
                    if (fits)
                    begin
                        lane_next[s][l].num      = NUM_W'(rem - dsh);
                        lane_next[s][l].quo[BIT] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (adv[s])
                begin
                    valid_reg[s] <= (s == 0) ? in_valid : valid_reg[s == 0 ? 0 : s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    lane_reg[s]  <= lane_next[s];
                    flags_reg[s] <= (s == 0) ? in_flags : flags_reg[s == 0 ? 0 : s-1];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign out_lane  = lane_reg[QUO_W-1];
    assign out_flags = flags_reg[QUO_W-1];

endmodule

// File: sv/vertex_transform_viewport_core.sv
// Vertex transform, perspective divide and viewport mapping, top level.
// Uses vtv_pkg, vtv_mac, vtv_prep, vtv_div and assert_macros.svh.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  request  | in_valid/in_stall, vert_x..vert_w    | in
//  result   | out_valid/out_stall, screen_x..w_zero| out
//  config   | cfg_write_en, cfg_index, cfg_data    | in
//
// One request per cycle sustained while out_stall is low; stages are 2
// multiply/sum, 3 numerator prep, 16 divider bit, 1 output/saturation.
// The 16-stage bit-per-stage divider sets the depth.
// Reset loads the identity matrix and a 128x64 frame; pipeline empties.
// Each stage advances when empty or when the stage after it advances, so
// bubbles collapse and in_stall rises only once every stage is full.
`include "assert_macros.svh"

module vertex_transform_viewport_core
    import vtv_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [ROW_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [COORD_W-1:0]   vert_x,
    input  logic signed [COORD_W-1:0]   vert_y,
    input  logic signed [COORD_W-1:0]   vert_z,
    input  logic signed [COORD_W-1:0]   vert_w,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SCREEN_W-1:0]  screen_x,
    output logic signed [SCREEN_W-1:0]  screen_y,
    output logic signed [DEPTH_W-1:0]   depth,
    output logic                        depth_in_range,
    output logic                        w_zero
);

    // configuration
    logic [ROW_W-1:0]  row_reg [4];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_W'(64'h0000_0000_0000_1000);
            row_reg[1] <= ROW_W'(64'h0000_0000_1000_0000);
            row_reg[2] <= ROW_W'(64'h0000_1000_0000_0000);
            row_reg[3] <= ROW_W'(64'h1000_0000_0000_0000);
            width_reg  <= SIZE_W'(128);
            height_reg <= SIZE_W'(64);
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW0:   row_reg[0] <= cfg_data;
                REG_ROW1:   row_reg[1] <= cfg_data;
                REG_ROW2:   row_reg[2] <= cfg_data;
                REG_ROW3:   row_reg[3] <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                default:    ; // unused index: write dropped
            endcase
        end
    end

    // pipeline
    vert_t      vin;
    clip_vec_t  clip;
    logic       mac_ready, mac_valid;
    logic       prep_ready, prep_valid;
    logic       div_ready, div_valid;
    div_lane_t  prep_lane [NUM_LANES];
    div_lane_t  div_lane  [NUM_LANES];
    flags_t     prep_flags, div_flags;
    logic       adv_out;
    logic       out_valid_reg;

    assign vin.x = vert_x;
    assign vin.y = vert_y;
    assign vin.z = vert_z;
    assign vin.w = vert_w;

    vtv_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (mac_ready),
        .in_vert   (vin),
        .row       (row_reg),
        .out_valid (mac_valid),
        .out_ready (prep_ready),
        .out_clip  (clip)
    );

    vtv_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mac_valid),
        .in_ready     (prep_ready),
        .in_clip      (clip),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .out_valid    (prep_valid),
        .out_ready    (div_ready),
        .out_lane     (prep_lane),
        .out_flags    (prep_flags)
    );

    vtv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (div_ready),
        .in_lane   (prep_lane),
        .in_flags  (prep_flags),
        .out_valid (div_valid),
        .out_ready (adv_out),
        .out_lane  (div_lane),
        .out_flags (div_flags)
    );

    assign in_stall = !mac_ready;

    // Sign, clamp: positive side stops at max, negative at -max-1.
    function automatic logic signed [SCREEN_W-1:0] sat_screen(input div_lane_t d);
        logic [QUO_W:0] mag;
        logic [QUO_W:0] lim;
        mag = d.ovf ? '1 : {1'b0, d.quo};
        lim = (QUO_W+1)'(1) << (SCREEN_W - 1);
        if (d.neg)
            sat_screen = (mag >= lim) ? {1'b1, {(SCREEN_W-1){1'b0}}}
                                      : SCREEN_W'(0 - mag[SCREEN_W-1:0]);
        else
            sat_screen = (mag >= lim - 1'b1) ? {1'b0, {(SCREEN_W-1){1'b1}}}
                                             : SCREEN_W'(mag);
    endfunction

    function automatic logic signed [DEPTH_W-1:0] sat_depth(input div_lane_t d);
        logic [QUO_W:0] mag;
        logic [QUO_W:0] lim;
        mag = d.ovf ? '1 : {1'b0, d.quo};
        lim = (QUO_W+1)'(1) << (DEPTH_W - 1);
        if (d.neg)
            sat_depth = (mag >= lim) ? {1'b1, {(DEPTH_W-1){1'b0}}}
                                     : DEPTH_W'(0 - mag[DEPTH_W-1:0]);
        else
            sat_depth = (mag >= lim - 1'b1) ? {1'b0, {(DEPTH_W-1){1'b1}}}
                                            : DEPTH_W'(mag);
    endfunction

    // output register
    logic signed [SCREEN_W-1:0] sx_reg, sy_reg;
    logic signed [DEPTH_W-1:0]  dz_reg;
    logic                       inr_reg, wz_reg;

    assign adv_out = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv_out)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && div_valid)
        begin
            // zero clip w: screen_x, screen_y and depth forced to zero
            sx_reg  <= div_flags.w_zero ? '0 : sat_screen(div_lane[LANE_X]);
            sy_reg  <= div_flags.w_zero ? '0 : sat_screen(div_lane[LANE_Y]);
            dz_reg  <= div_flags.w_zero ? '0 : sat_depth(div_lane[LANE_Z]);
            inr_reg <= div_flags.in_range;
            wz_reg  <= div_flags.w_zero;
        end
    end

    assign out_valid      = out_valid_reg;
    assign screen_x       = sx_reg;
    assign screen_y       = sy_reg;
    assign depth          = dz_reg;
    assign depth_in_range = inr_reg;
    assign w_zero         = wz_reg;

    `VTV_ASSERT_SAME(a_wzero_clears, out_valid && w_zero, screen_x == '0 && screen_y == '0 && depth == '0 && !depth_in_range, "w_zero result has nonzero fields")
    `VTV_ASSERT_SAME(a_inr_depth, out_valid && depth_in_range, depth <= DEPTH_W'(8192) && depth >= -DEPTH_W'(8192), "in-range depth beyond one")
    `VTV_ASSERT_SAME(a_stall_full, in_stall, out_valid && out_stall, "input stalled while output free")

endmodule

// File: tb/tb.sv
// Testbench for vertex_transform_viewport_core: transform, divide, viewport.
// Depends on vtv_pkg and the core RTL; self-checking with a built-in predictor.
module tb;
    import vtv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [11:0] sx;
        logic signed [11:0] sy;
        logic signed [15:0] dz;
        logic               inr;
        logic               wz;
    } pixel_t;

    // Scoreboard: owns the matrix/frame shadow and the queue of pending pixels.
    class vertex_board;
        logic [63:0] rows [4];
        logic [11:0] fw, fh;
        pixel_t      pending [$];
        int          errors;

        function new();
            rows[0] = 64'd4096;
            rows[1] = 64'd268435456;
            rows[2] = 64'd17592186044416;
            rows[3] = 64'd1152921504606846976;
            fw = 12'd128;
            fh = 12'd64;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [63:0] val);
            case (idx)
                REG_ROW0:   rows[0] = val;
                REG_ROW1:   rows[1] = val;
                REG_ROW2:   rows[2] = val;
                REG_ROW3:   rows[3] = val;
                REG_WIDTH:  fw = val[11:0];
                REG_HEIGHT: fh = val[11:0];
                default:    ;
            endcase
        endfunction

        static function longint clampv(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Project one vertex; SV integer division truncates toward zero.
        function void note_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                  logic signed [15:0] vz, logic signed [15:0] vw);
            longint clip [4];
            longint coord [4];
            longint cw, wm1, hm1, a, b;
            pixel_t p;
            coord[0] = vx; coord[1] = vy; coord[2] = vz; coord[3] = vw;
            for (int r = 0; r < 4; r++)
            begin
                clip[r] = 0;
                for (int k = 0; k < 4; k++)
                    clip[r] += longint'($signed(rows[r][16*k +: 16])) * coord[k];
            end
            cw = clip[3];
            if (cw == 0)
            begin
                p.sx = 0; p.sy = 0; p.dz = 0; p.inr = 0; p.wz = 1;
            end
            else
            begin
                wm1 = (fw == 0 ? 1 : longint'(fw)) - 1;
                hm1 = (fh == 0 ? 1 : longint'(fh)) - 1;
                p.sx = clampv(((clip[0] + cw) * wm1) / (2 * cw), -2048, 2047);
                p.sy = clampv(((cw - clip[1]) * hm1) / (2 * cw), -2048, 2047);
                p.dz = clampv((clip[2] * 8192) / cw, -32768, 32767);
                a = clip[2] < 0 ? -clip[2] : clip[2];
                b = cw < 0 ? -cw : cw;
                p.inr = a <= b;
                p.wz = 0;
            end
            pending.push_back(p);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result sx=%0d sy=%0d", got.sx, got.sy);
                return;
            end
            want = pending.pop_front();
            if (got.sx !== want.sx || got.sy !== want.sy || got.dz !== want.dz ||
                got.inr !== want.inr || got.wz !== want.wz)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp %0d %0d %0d %0b %0b got %0d %0d %0d %0b %0b",
                             want.sx, want.sy, want.dz, want.inr, want.wz,
                             got.sx, got.sy, got.dz, got.inr, got.wz);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [15:0] vert_x = 0, vert_y = 0, vert_z = 0, vert_w = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [11:0] screen_x, screen_y;
    logic signed [15:0] depth;
    logic depth_in_range, w_zero;

    vertex_board board = new();
    bit  quiet_tail = 0;   // no idling in the final stretch
    int  stall_left = 0;
    int  watchdog = 0;
    localparam int WATCH_LIMIT = 2000;

    vertex_transform_viewport_core dut (.*);

    always #6 clk = ~clk;

    // Result side: random stall bursts, check on every accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_pixel('{screen_x, screen_y, depth, depth_in_range, w_zero});
            if (quiet_tail)
                out_stall <= 0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                out_stall <= 1;
            end
            else
                out_stall <= 0;
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCH_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // One write cycle, with cfg_write_en dropped before the task returns so back-to-back writes stay apart.
    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        cfg_write_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write_en <= 0;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    // Present one request, hold it until accepted.
    task automatic send_vertex(logic [15:0] vx, logic [15:0] vy,
                               logic [15:0] vz, logic [15:0] vw);
        if (!quiet_tail && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1;
        vert_x <= vx; vert_y <= vy; vert_z <= vz; vert_w <= vw;
        do @(posedge clk); while (in_stall);
        board.note_vertex(vx, vy, vz, vw);
    endtask

    task automatic go_idle();
        in_valid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);   // margin past the full pipeline
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_row();
        logic [63:0] r;
        for (int k = 0; k < 4; k++)
            case ($urandom_range(0, 4))
                0: r[16*k +: 16] = 16'h0000;
                1: r[16*k +: 16] = 16'h1000;
                2: r[16*k +: 16] = 16'hF000;
                default: r[16*k +: 16] = 16'($urandom);
            endcase
        return r;
    endfunction

    task automatic random_vertices(int n);
        for (int i = 0; i < n; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(),
                        $urandom_range(0, 3) == 0 ? 16'd256 : rand_coord());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: identity matrix, extremes, w zero, depth edges.
        send_vertex(16'd0, 16'd0, 16'd0, 16'd256);
        send_vertex(16'd256, 16'hFF00, 16'd256, 16'd256);
        send_vertex(16'hFF00, 16'd256, 16'hFF00, 16'd256);
        send_vertex(16'd0, 16'd0, 16'd0, 16'd0);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 16'd1);
        send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_vertex(16'd512, 16'd512, 16'd257, 16'd256);
        send_vertex(16'd100, 16'd100, 16'd100, 16'hFF00);
        send_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        go_idle();   // sender waits for every pending result

        // Frame extremes: zero, one, 2048, 4095; then random matrices.
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_HEIGHT, 64'd1);
        send_vertex(16'd256, 16'd256, 16'd0, 16'd256);
        send_vertex(16'hFF00, 16'hFF00, 16'd0, 16'd256);
        go_idle();
        write_reg(REG_WIDTH, 64'd2048);
        write_reg(REG_HEIGHT, 64'd4095);
        random_vertices(10);
        go_idle();
        write_reg(REG_ROW3, 64'd0);   // every vertex hits w zero
        random_vertices(4);
        go_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_ROW0, rand_row());
            write_reg(REG_ROW1, rand_row());
            write_reg(REG_ROW2, ph == 0 ? 64'hFFFF_FFFF_FFFF_FFFF : rand_row());
            write_reg(REG_ROW3, ph == 1 ? 64'h7FFF_7FFF_7FFF_7FFF :
                                ph == 2 ? 64'h1000_0000_0000_0000 : rand_row());
            write_reg(REG_WIDTH, 64'($urandom_range(1, 2048)));
            write_reg(REG_HEIGHT, 64'($urandom_range(1, 2048)));
            if (ph == 5)
                quiet_tail = 1;
            random_vertices(100);
            go_idle();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
